@@ rtl/key_value_field_extractor_macros.svh @@
// ----------------------------------------------------------------------------
// key_value_field_extractor_macros
// Assertion macros shared by the key/value extractor RTL.
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_FIELD_EXTRACTOR_MACROS_SVH
`define KEY_VALUE_FIELD_EXTRACTOR_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define KVFE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define KVFE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define KVFE_ASSERT_NOW(lbl, ante, cons, msg)
`define KVFE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/kvfe_pkg.sv @@
// ----------------------------------------------------------------------------
// kvfe_pkg
// Constants, types and helper functions of the key/value field extractor.
// ----------------------------------------------------------------------------
package kvfe_pkg;

	// sizes
	localparam int KEY_MAX   = 8;
	localparam int VALUE_MAX = 29;
	localparam int LINE_MAX  = 1022;
	localparam int WIN_DEPTH = KEY_MAX + 2;

	localparam int KEY_W   = 64;
	localparam int KLEN_W  = 4;
	localparam int CNT_W   = $clog2(VALUE_MAX + 1);
	localparam int ADDR_W  = (VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1;
	localparam int READS_W = $clog2(LINE_MAX + 1);
	localparam int KSEL_W  = $clog2(KEY_MAX + 1);

	// register indexes
	localparam logic REG_KEY_CHARS  = 1'b0;
	localparam logic REG_KEY_LENGTH = 1'b1;

	// register reset values
	localparam logic [KEY_W-1:0]  KEY_CHARS_RST  = KEY_W'(12393);
	localparam logic [KLEN_W-1:0] KEY_LENGTH_RST = KLEN_W'(2);

	// characters
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_EQ    = 8'h3D;

	// capture phases
	localparam logic [1:0] PH_SEARCH  = 2'd0;
	localparam logic [1:0] PH_CAPTURE = 2'd1;
	localparam logic [1:0] PH_DONE    = 2'd2;

	// per-pattern line state
	typedef struct packed {
		logic [1:0]       phase;
		logic [CNT_W-1:0] count;
	} path_t;

	// pattern hits of the window
	typedef struct packed {
		logic amp_hit;
		logic quest_hit;
	} hit_t;

	// line-end request to the drain unit
	typedef struct packed {
		logic             start;
		logic             found;
		logic             sel_amp;
		logic [CNT_W-1:0] cnt;
	} emit_t;

	// key length in use, saturated
	function automatic logic [KSEL_W-1:0] eff_klen(input logic [KLEN_W-1:0] len);
		logic [KSEL_W-1:0] k;
		k = KSEL_W'(len);
		if (int'(len) > KEY_MAX) k = KSEL_W'(KEY_MAX);
		if (int'(k) > 8) k = KSEL_W'(8);
		return k;
	endfunction

	// key character j, zero beyond the register
	function automatic logic [7:0] key_byte(input logic [KEY_W-1:0] key, input int j);
		return 8'(key >> (8 * j));
	endfunction

	// one byte through the capture phase of one pattern
	function automatic path_t path_step(input path_t cur, input logic [7:0] c,
			input logic proc, input logic hit);
		path_t            nxt;
		logic [CNT_W-1:0] inc;
		nxt = cur;
		inc = cur.count + CNT_W'(1);
		if (proc && cur.phase == PH_CAPTURE) begin
			if (c == CH_AMP || c == CH_SEMI) begin
				nxt.phase = PH_DONE;
			end else begin
				nxt.count = inc;
				if (inc >= CNT_W'(VALUE_MAX)) nxt.phase = PH_DONE;
			end
		end
		if (proc && nxt.phase == PH_SEARCH && hit) begin
			nxt.phase = PH_CAPTURE;
			nxt.count = '0;
		end
		return nxt;
	endfunction

endpackage

@@ rtl/key_value_field_extractor.sv @@
// ----------------------------------------------------------------------------
// key_value_field_extractor
// Pulls the value of one key out of a received line, query-string style.
//
//   channel  dir  handshake              payload
//   item     in   item_valid/item_stall  rx_byte
//   result   out  res_valid/res_stall    found, has_char, value_char, last
//   config   in   cfg_we                 cfg_index, cfg_data
//
// A byte is taken every cycle while no line is being read out.
// A line end issues one read per value character (one empty slot if the value
// is empty) on the value store RAM, with item_stall high; the next byte goes in after the last read is issued.
// Results leave through an output register after the RAM's registered read;
// result stalls beyond one held transfer stretch the read-out.
// Reset clears all line state at once; value stores need no clearing.
// ----------------------------------------------------------------------------
`include "key_value_field_extractor_macros.svh"

module key_value_field_extractor (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [7:0]                 rx_byte,
	output logic                       res_valid,
	input  logic                       res_stall,
	output logic                       found,
	output logic                       has_char,
	output logic [7:0]                 value_char,
	output logic                       last,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [kvfe_pkg::KEY_W-1:0] cfg_data
);
	import kvfe_pkg::*;

	logic [KEY_W-1:0]   key_chars_q;
	logic [KLEN_W-1:0]  key_length_q;
	path_t              amp_q, quest_q, amp_nx, quest_nx;
	logic [READS_W-1:0] reads_q, reads_inc;

	logic              item_acc, proc, line_end, busy;
	hit_t              hit;
	emit_t             emit;
	logic              amp_we, quest_we, amp_re, quest_re;
	logic [ADDR_W-1:0] raddr;
	logic [7:0]        amp_rdata, quest_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_chars_q  <= KEY_CHARS_RST;
			key_length_q <= KEY_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_CHARS:  key_chars_q  <= cfg_data;
				REG_KEY_LENGTH: key_length_q <= cfg_data[KLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// byte classification
	assign item_stall = busy;
	assign item_acc   = item_valid && !item_stall;
	assign proc       = (rx_byte >= CH_SPACE);
	assign reads_inc  = reads_q + READS_W'(1);
	assign line_end   = (rx_byte == CH_NL) || (reads_inc >= READS_W'(LINE_MAX));

	// pattern window
	kvfe_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.shift      (item_acc && proc),
		.clear      (item_acc && line_end),
		.c          (rx_byte),
		.key_chars  (key_chars_q),
		.key_length (key_length_q),
		.hit        (hit)
	);

	// capture phases of both patterns
	assign amp_nx   = path_step(amp_q, rx_byte, proc, hit.amp_hit);
	assign quest_nx = path_step(quest_q, rx_byte, proc, hit.quest_hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q   <= '{phase: PH_SEARCH, count: '0};
			quest_q <= '{phase: PH_SEARCH, count: '0};
			reads_q <= '0;
		end else if (item_acc) begin
			if (line_end) begin
				amp_q   <= '{phase: PH_SEARCH, count: '0};
				quest_q <= '{phase: PH_SEARCH, count: '0};
				reads_q <= '0;
			end else begin
				amp_q   <= amp_nx;
				quest_q <= quest_nx;
				reads_q <= reads_inc;
			end
		end
	end

	// value store writes
	assign amp_we   = item_acc && proc && amp_q.phase == PH_CAPTURE &&
		rx_byte != CH_AMP && rx_byte != CH_SEMI;
	assign quest_we = item_acc && proc && quest_q.phase == PH_CAPTURE &&
		rx_byte != CH_AMP && rx_byte != CH_SEMI;

	kvfe_ram #(.DEPTH(VALUE_MAX), .WIDTH(8)) u_amp_ram (
		.clk   (clk),
		.we    (amp_we),
		.waddr (amp_q.count[ADDR_W-1:0]),
		.wdata (rx_byte),
		.re    (amp_re),
		.raddr (raddr),
		.rdata (amp_rdata)
	);

	kvfe_ram #(.DEPTH(VALUE_MAX), .WIDTH(8)) u_quest_ram (
		.clk   (clk),
		.we    (quest_we),
		.waddr (quest_q.count[ADDR_W-1:0]),
		.wdata (rx_byte),
		.re    (quest_re),
		.raddr (raddr),
		.rdata (quest_rdata)
	);

	// line end: '&' value wins over '?' value
	always_comb begin
		emit.start   = item_acc && line_end;
		emit.sel_amp = (amp_nx.phase != PH_SEARCH);
		emit.found   = (amp_nx.phase != PH_SEARCH) || (quest_nx.phase != PH_SEARCH);
		if (amp_nx.phase != PH_SEARCH) emit.cnt = amp_nx.count;
		else if (quest_nx.phase != PH_SEARCH) emit.cnt = quest_nx.count;
		else emit.cnt = '0;
	end

	kvfe_drain u_drain (
		.clk         (clk),
		.arst_n      (arst_n),
		.emit        (emit),
		.busy        (busy),
		.amp_re      (amp_re),
		.quest_re    (quest_re),
		.raddr       (raddr),
		.amp_rdata   (amp_rdata),
		.quest_rdata (quest_rdata),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.found       (found),
		.has_char    (has_char),
		.value_char  (value_char),
		.last        (last)
	);

	// checks
	`KVFE_ASSERT_NEXT(a_stall_after_line_end, item_acc && line_end, item_stall, "no read-out after line end")
	`KVFE_ASSERT_NOW(a_empty_is_last, res_valid && !has_char, last && value_char == 8'h00, "bad empty result")
	`KVFE_ASSERT_NOW(a_no_write_in_drain, busy, !amp_we && !quest_we, "store written during read-out")
	`KVFE_ASSERT_NOW(a_amp_write_in_range, amp_we, amp_q.count < CNT_W'(VALUE_MAX), "amp store overrun")
	`KVFE_ASSERT_NOW(a_quest_write_in_range, quest_we, quest_q.count < CNT_W'(VALUE_MAX), "quest store overrun")

endmodule

@@ rtl/kvfe_ram.sv @@
// ----------------------------------------------------------------------------
// kvfe_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kvfe_ram #(
	parameter int DEPTH = 29,
	parameter int WIDTH = 8
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// read port, registered, holds when idle
	always_ff @(posedge clk) begin
		if (re) rdata <= mem[raddr];
	end

endmodule

@@ rtl/kvfe_window.sv @@
// ----------------------------------------------------------------------------
// kvfe_window
// Window of the last kept bytes and the lead+key+'=' pattern compare.
// ----------------------------------------------------------------------------
module kvfe_window (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       shift,
	input  logic                       clear,
	input  logic [7:0]                 c,
	input  logic [kvfe_pkg::KEY_W-1:0]  key_chars,
	input  logic [kvfe_pkg::KLEN_W-1:0] key_length,
	output kvfe_pkg::hit_t             hit
);
	import kvfe_pkg::*;

	logic [7:0]        win_q  [WIN_DEPTH];
	logic [7:0]        win_nx [WIN_DEPTH];
	logic              key_ok    [KEY_MAX+1];
	logic              lead_amp  [KEY_MAX+1];
	logic              lead_ques [KEY_MAX+1];
	logic [KSEL_W-1:0] klen;
	logic              eq_ok;

	// window as it stands once the current byte is in
	always_comb begin
		for (int i = 0; i < WIN_DEPTH - 1; i++) win_nx[i] = win_q[i+1];
		win_nx[WIN_DEPTH-1] = c;
	end

	// compare for every possible key length, then pick one
	always_comb begin
		for (int k = 0; k <= KEY_MAX; k++) begin
			key_ok[k] = 1'b1;
			for (int j = 0; j < k; j++) begin
				if (win_nx[WIN_DEPTH-1-k+j] != key_byte(key_chars, j)) key_ok[k] = 1'b0;
			end
			lead_amp[k]  = (win_nx[WIN_DEPTH-2-k] == CH_AMP);
			lead_ques[k] = (win_nx[WIN_DEPTH-2-k] == CH_QUEST);
		end
	end

	assign klen          = eff_klen(key_length);
	assign eq_ok         = (win_nx[WIN_DEPTH-1] == CH_EQ);
	assign hit.amp_hit   = eq_ok && key_ok[klen] && lead_amp[klen];
	assign hit.quest_hit = eq_ok && key_ok[klen] && lead_ques[klen];

	// shift line, cleared at end of line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_DEPTH; i++) win_q[i] <= '0;
		end else if (clear) begin
			for (int i = 0; i < WIN_DEPTH; i++) win_q[i] <= '0;
		end else if (shift) begin
			for (int i = 0; i < WIN_DEPTH; i++) win_q[i] <= win_nx[i];
		end
	end

endmodule

@@ rtl/kvfe_drain.sv @@
// ----------------------------------------------------------------------------
// kvfe_drain
// Reads the chosen value store out one character per result.
// ----------------------------------------------------------------------------
module kvfe_drain (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kvfe_pkg::emit_t            emit,
	output logic                       busy,
	output logic                       amp_re,
	output logic                       quest_re,
	output logic [kvfe_pkg::ADDR_W-1:0] raddr,
	input  logic [7:0]                 amp_rdata,
	input  logic [7:0]                 quest_rdata,
	output logic                       res_valid,
	input  logic                       res_stall,
	output logic                       found,
	output logic                       has_char,
	output logic [7:0]                 value_char,
	output logic                       last
);
	import kvfe_pkg::*;

	// read sequencer
	logic              busy_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              sel_amp_q;
	logic              found_q;
	// read stage
	logic              valid_s1, last_s1, found_s1, has_s1, sel_s1;
	// output stage
	logic              valid_s2, last_s2, found_s2, has_s2;
	logic [7:0]        char_s2;

	logic issue, move, last_slot, slot_has;

	assign move      = valid_s1 && (!valid_s2 || !res_stall);
	assign issue     = busy_q && (!valid_s1 || move);
	assign slot_has  = (cnt_q != '0);
	assign last_slot = !slot_has || (CNT_W'(addr_q) + CNT_W'(1) == cnt_q);

	assign busy     = busy_q;
	assign raddr    = addr_q;
	assign amp_re   = issue && slot_has && sel_amp_q;
	assign quest_re = issue && slot_has && !sel_amp_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (emit.start) begin
			busy_q <= 1'b1;
		end else if (issue && last_slot) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.start) begin
			addr_q    <= '0;
			cnt_q     <= emit.cnt;
			sel_amp_q <= emit.sel_amp;
			found_q   <= emit.found;
		end else if (issue) begin
			addr_q <= addr_q + ADDR_W'(1);
		end
	end

	// read stage: memory data arrives with these marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (issue) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			last_s1  <= last_slot;
			found_s1 <= found_q;
			has_s1   <= slot_has;
			sel_s1   <= sel_amp_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (move) begin
			valid_s2 <= 1'b1;
		end else if (!res_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			last_s2  <= last_s1;
			found_s2 <= found_s1;
			has_s2   <= has_s1;
			if (!has_s1) char_s2 <= '0;
			else char_s2 <= sel_s1 ? amp_rdata : quest_rdata;
		end
	end

	assign res_valid  = valid_s2;
	assign found      = found_s2;
	assign has_char   = has_s2;
	assign value_char = char_s2;
	assign last       = last_s2;

endmodule
